// File: hw/rtl/mobm_pkg.sv
// mobm_pkg: shared types and constants for the box overlap matcher.
// Used by mobm_table, mobm_overlap and max_overlap_box_matcher; no dependencies.

package mobm_pkg;

    // command codes carried in the func field
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // fixed result field widths
    localparam int PIDX_W     = 16;
    localparam int CAND_IDX_W = 6;
    localparam int AREA_W     = 24;

    localparam logic [PIDX_W-1:0] PIDX_MAX = '1;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    // marks a candidate moving down the scan pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

endpackage

// File: hw/rtl/mobm_table.sv
// mobm_table: candidate box memory, one write port, one registered read port.
// The scan tag and index travel with the read so they line up with the data.
// Depends on mobm_pkg.

module mobm_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48,
    parameter int IDX_W = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  mobm_pkg::t_tag       i_rd_tag,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output mobm_pkg::t_tag       o_rd_tag,
    output logic [IDX_W-1:0]     o_rd_idx,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    mobm_pkg::t_tag   r_rd_tag;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_tag.valid) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        r_rd_idx <= i_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag <= i_rd_tag;
        end
    end

    assign o_rd_tag  = r_rd_tag;
    assign o_rd_idx  = r_rd_idx;
    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/mobm_overlap.sv
// mobm_overlap: two-stage intersection area unit shared by every candidate.
// Stage 1 clips the edges to side lengths, stage 2 multiplies them.
// Depends on mobm_pkg.

module mobm_overlap #(
    parameter int COORD_BITS = 12,
    parameter int IDX_W      = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mobm_pkg::t_tag          i_tag,
    input  logic [IDX_W-1:0]        i_idx,
    input  logic [4*COORD_BITS-1:0] i_cand,   // {x, y, w, h}
    input  logic [4*COORD_BITS-1:0] i_det,    // {x, y, w, h}
    output mobm_pkg::t_tag          o_tag,
    output logic [IDX_W-1:0]        o_idx,
    output logic [2*COORD_BITS-1:0] o_area
);

    localparam int CB = COORD_BITS;

    logic [CB-1:0] cx, cy, cw, ch, dx, dy, dw, dh;
    logic [CB:0]   c_right, c_bottom, d_right, d_bottom;
    logic [CB:0]   left, top, right, bottom;
    logic [CB:0]   span_x, span_y;
    logic [CB-1:0] len_x, len_y;

    logic [CB-1:0]    r_len_x, r_len_y;
    logic [IDX_W-1:0] r_idx1, r_idx2;
    mobm_pkg::t_tag   r_tag1, r_tag2;
    logic [2*CB-1:0]  r_area;

    assign {cx, cy, cw, ch} = i_cand;
    assign {dx, dy, dw, dh} = i_det;

    always_comb begin
        c_right  = {1'b0, cx} + {1'b0, cw};
        c_bottom = {1'b0, cy} + {1'b0, ch};
        d_right  = {1'b0, dx} + {1'b0, dw};
        d_bottom = {1'b0, dy} + {1'b0, dh};
        left     = (cx > dx) ? {1'b0, cx} : {1'b0, dx};
        top      = (cy > dy) ? {1'b0, cy} : {1'b0, dy};
        right    = (c_right < d_right) ? c_right : d_right;
        bottom   = (c_bottom < d_bottom) ? c_bottom : d_bottom;
        span_x   = right - left;
        span_y   = bottom - top;
        // a clipped side never exceeds either box's own width, so it fits CB bits
        len_x    = (right > left) ? span_x[CB-1:0] : '0;
        len_y    = (bottom > top) ? span_y[CB-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        r_len_x <= len_x;
        r_len_y <= len_y;
        r_idx1  <= i_idx;
        r_area  <= {{CB{1'b0}}, r_len_x} * {{CB{1'b0}}, r_len_y};
        r_idx2  <= r_idx1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    assign o_tag  = r_tag2;
    assign o_idx  = r_idx2;
    assign o_area = r_area;

endmodule

// File: hw/rtl/max_overlap_box_matcher.sv
// max_overlap_box_matcher: top level, command decode, scan sequencer, best tracking.
// Instantiates mobm_table and mobm_overlap; depends on mobm_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one command per transaction:
//   clear, append a candidate box, or query with a detection box. The output
//   channel (o_out_valid / i_out_ready) returns exactly one result transaction
//   per command, in order.
//   Clear and append go from acceptance straight to the done state; the result
//   passes through the pending result register into the output register.
//   A query walks the stored candidates through the single read port of the
//   candidate memory and the shared two-stage area unit, one candidate a cycle;
//   the result is loaded into the output register once the last candidate
//   has left the area unit. With an empty table a query goes straight to the
//   done state like clear and append. The next command is taken after the load.
//   Synchronous active-low reset empties the table and zeroes the person
//   counter; memory contents are not cleared and need no sweep.
//   A stalled receiver holds the result in the output register; the block
//   still accepts and works the next command, and only waits before handing
//   over a second result while the first is still held.

module max_overlap_box_matcher #(
    parameter int MAX_CANDIDATES = 64,
    parameter int COORD_BITS     = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_func,
    input  logic [COORD_BITS-1:0] i_box_x,
    input  logic [COORD_BITS-1:0] i_box_y,
    input  logic [COORD_BITS-1:0] i_box_width,
    input  logic [COORD_BITS-1:0] i_box_height,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_matched,
    output logic [15:0]           o_person_index,
    output logic [5:0]            o_candidate_index,
    output logic [23:0]           o_overlap_area,
    output logic                  o_dropped
);

    localparam int CB      = COORD_BITS;
    localparam int BOX_W   = 4 * CB;
    localparam int FULL_W  = 2 * CB;
    localparam int IDX_W   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CNT_W   = $clog2(MAX_CANDIDATES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CANDIDATES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // sequencer and table state
    logic [1:0]                  r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [mobm_pkg::PIDX_W-1:0] r_pidx, n_pidx;
    logic [IDX_W-1:0]            r_rd_idx, n_rd_idx;
    logic [BOX_W-1:0]            r_det, n_det;

    // running best of the current query
    logic [FULL_W-1:0]           r_best, n_best;
    logic [IDX_W-1:0]            r_best_idx, n_best_idx;

    // pending result waiting for the output register
    logic                            r_res_matched, n_res_matched;
    logic [mobm_pkg::PIDX_W-1:0]     r_res_pidx, n_res_pidx;
    logic [mobm_pkg::CAND_IDX_W-1:0] r_res_cidx, n_res_cidx;
    logic [mobm_pkg::AREA_W-1:0]     r_res_area, n_res_area;
    logic                            r_res_dropped, n_res_dropped;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_matched;
    logic [mobm_pkg::PIDX_W-1:0]     r_out_pidx;
    logic [mobm_pkg::CAND_IDX_W-1:0] r_out_cidx;
    logic [mobm_pkg::AREA_W-1:0]     r_out_area;
    logic                            r_out_dropped;
    logic                            out_load;

    logic             in_acc;
    logic             wr_en;
    mobm_pkg::t_tag   rd_tag;
    logic             rd_last;
    mobm_pkg::t_tag   tbl_tag;
    logic [IDX_W-1:0] tbl_idx;
    logic [BOX_W-1:0] tbl_data;
    mobm_pkg::t_tag   ov_tag;
    logic [IDX_W-1:0] ov_idx;
    logic [FULL_W-1:0] ov_area;
    logic [BOX_W-1:0] in_box;

    assign in_box     = {i_box_x, i_box_y, i_box_width, i_box_height};
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_en      = in_acc && (i_func == mobm_pkg::FUNC_APPEND) && (r_count < CNT_MAX);

    // issue one read a cycle while scanning; last marks the final stored entry
    assign rd_last      = (CNT_W'(r_rd_idx) == (r_count - CNT_ONE));
    assign rd_tag.valid = (r_state == S_SCAN);
    assign rd_tag.last  = rd_last;

    mobm_table #(
        .DEPTH (MAX_CANDIDATES),
        .WIDTH (BOX_W),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (in_box),
        .i_rd_tag  (rd_tag),
        .i_rd_addr (r_rd_idx),
        .o_rd_tag  (tbl_tag),
        .o_rd_idx  (tbl_idx),
        .o_rd_data (tbl_data)
    );

    mobm_overlap #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_overlap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (tbl_tag),
        .i_idx   (tbl_idx),
        .i_cand  (tbl_data),
        .i_det   (r_det),
        .o_tag   (ov_tag),
        .o_idx   (ov_idx),
        .o_area  (ov_area)
    );

    // output register loads in the done state when empty or being emptied this cycle
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pidx        = r_pidx;
        n_rd_idx      = r_rd_idx;
        n_det         = r_det;
        n_best        = r_best;
        n_best_idx    = r_best_idx;
        n_res_matched = r_res_matched;
        n_res_pidx    = r_res_pidx;
        n_res_cidx    = r_res_cidx;
        n_res_area    = r_res_area;
        n_res_dropped = r_res_dropped;

        // strict greater keeps the earliest candidate on equal areas
        if (ov_tag.valid && (ov_area > r_best)) begin
            n_best     = ov_area;
            n_best_idx = ov_idx;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_matched = 1'b0;
                    n_res_pidx    = '0;
                    n_res_cidx    = '0;
                    n_res_area    = '0;
                    n_res_dropped = 1'b0;
                    n_rd_idx      = '0;
                    n_best        = '0;
                    n_best_idx    = '0;
                    n_det         = in_box;
                    n_state       = S_DONE;
                    unique case (i_func)
                        mobm_pkg::FUNC_CLEAR: begin
                            n_count = '0;
                            n_pidx  = '0;
                        end
                        mobm_pkg::FUNC_APPEND: begin
                            if (r_count < CNT_MAX) begin
                                n_count = r_count + CNT_ONE;
                            end else begin
                                n_res_dropped = 1'b1;
                            end
                        end
                        mobm_pkg::FUNC_QUERY: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            // unused command: no change to the table or person counter, all-zero result
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (ov_tag.valid && ov_tag.last) begin
                    n_state = S_DONE;
                    if (n_best != '0) begin
                        n_res_matched = 1'b1;
                        n_res_pidx    = r_pidx;
                        n_res_cidx    = mobm_pkg::CAND_IDX_W'(n_best_idx);
                        n_res_area    = (n_best > FULL_W'(mobm_pkg::AREA_MAX)) ?
                                        mobm_pkg::AREA_MAX : mobm_pkg::AREA_W'(n_best);
                        if (r_pidx != mobm_pkg::PIDX_MAX) begin
                            n_pidx = r_pidx + mobm_pkg::PIDX_W'(1);
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pidx      <= n_pidx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx      <= n_rd_idx;
        r_det         <= n_det;
        r_best        <= n_best;
        r_best_idx    <= n_best_idx;
        r_res_matched <= n_res_matched;
        r_res_pidx    <= n_res_pidx;
        r_res_cidx    <= n_res_cidx;
        r_res_area    <= n_res_area;
        r_res_dropped <= n_res_dropped;
        if (out_load) begin
            r_out_matched <= r_res_matched;
            r_out_pidx    <= r_res_pidx;
            r_out_cidx    <= r_res_cidx;
            r_out_area    <= r_res_area;
            r_out_dropped <= r_res_dropped;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_matched         = r_out_matched;
    assign o_person_index    = r_out_pidx;
    assign o_candidate_index = r_out_cidx;
    assign o_overlap_area    = r_out_area;
    assign o_dropped         = r_out_dropped;

endmodule
